// File: design/cdsc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, calendar tables and arithmetic helpers for the date converter.
// No dependencies; imported by calendar_date_serial_converter.
package cdsc_pkg;

	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int SER_W  = 22;
	localparam int WD_W   = 3;
	localparam int ABS_W  = 24;  // absolute day count since 1 January of year 0
	localparam int EST_W  = 15;  // year estimate in the count-to-date path

	localparam int MAX_YEAR   = 9999;
	localparam int SERIAL_MAX = 2 ** SER_W - 1;
	localparam int BASE_RESET = 1000;

	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 48;

	// Input beat layout
	localparam int IN_DAY_LSB  = 0;
	localparam int IN_MON_LSB  = IN_DAY_LSB + DAY_W;
	localparam int IN_YEAR_LSB = IN_MON_LSB + MON_W;
	localparam int IN_SER_LSB  = IN_YEAR_LSB + YEAR_W;

	// Operation codes carried on s_tuser
	localparam logic KIND_DATE_TO_SERIAL = 1'b0;
	localparam logic KIND_SERIAL_TO_DATE = 1'b1;

	// Year candidate lanes around the reciprocal estimate
	localparam int LANES = 3;
	localparam logic [1:0] LANE_M1 = 2'd0;
	localparam logic [1:0] LANE_0  = 2'd1;
	localparam logic [1:0] LANE_P1 = 2'd2;

	// x / 100 as (x * 5243) >> 19, exact for x below 43699
	localparam logic [27:0] DIV100_MUL = 28'd5243;
	// ceil(2^32 * 400 / 146097): days to years, overestimates by under 1/256
	localparam logic [ABS_W-1:0] YEAR_RECIP = 24'd11759222;

	localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};
	localparam logic [8:0] CUM_COMMON [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	function automatic logic [8:0] div100(input logic [14:0] x);
		logic [27:0] p;
		p = 28'(x) * DIV100_MUL;
		return p[27:19];
	endfunction

	function automatic logic [ABS_W-1:0] mul365(input logic [14:0] x);
		return ABS_W'(x) * ABS_W'(365);
	endfunction

	// Days in years 0 .. y-1 from its registered pieces
	function automatic logic [ABS_W-1:0] db_from_parts(input logic [ABS_W-1:0] p365,
			input logic [14:0] y, input logic [8:0] q99, input logic [8:0] q399);
		logic [15:0] y3;
		y3 = 16'(y) + 16'd3;
		return p365 + ABS_W'(y3[15:2]) - ABS_W'(q99) + ABS_W'(q399[8:2]);
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
		logic [MON_W-1:0] idx;
		idx = m - 4'd1;
		if (m >= 4'd1 && m <= 4'd12) begin
			return MONTH_LEN[idx] + DAY_W'((m == 4'd2) && leap);
		end
		return '0;
	endfunction

	// Days in the year before the first of month m
	function automatic logic [8:0] cum_days(input logic [MON_W-1:0] m, input logic leap);
		logic [MON_W-1:0] idx;
		idx = m - 4'd1;
		if (m >= 4'd1 && m <= 4'd12) begin
			return CUM_COMMON[idx] + 9'((m > 4'd2) && leap);
		end
		return '0;
	endfunction

	function automatic logic [EST_W-1:0] cand_year(input logic [EST_W-1:0] est,
			input logic [1:0] lane);
		logic [EST_W-1:0] c;
		case (lane)
			LANE_M1: begin
				c = (est == '0) ? '0 : est - 15'd1;
			end
			LANE_P1: begin
				c = est + 15'd1;
			end
			default: begin
				c = est;
			end
		endcase
		return c;
	endfunction

endpackage

// File: design/calendar_date_serial_converter.sv
`timescale 1ns / 1ps
// Gregorian date <-> day count converter, nine-stage pipeline.
// Depends on cdsc_pkg for widths, calendar tables and arithmetic helpers.
//
// Usage
//  - Input stream (s_*): one beat per conversion. s_tuser is the kind:
//    0 turns day/month/year into a day count from 1 January of base_year,
//    1 turns a day count into day/month/year. Both give the weekday
//    (0 Monday .. 6 Sunday) and a valid flag.
//  - Output stream (m_*): one beat per input beat, in order. m_tuser is the
//    valid flag; on an invalid date or an out-of-range count all data is 0.
//  - cfg_wen/cfg_wdata write base_year; write only while the block is idle.
//  - Pipeline: nine register stages. Throughput: one beat per cycle while
//    the receiver does not stall the output, set by the single pass through
//    the pipeline (no stage iterates).
//  - Stall: each stage holds while the one ahead is full and stalled, so a
//    stalled receiver fills bubbles first and then drops s_tready; no beat
//    is lost or repeated.
//  - Reset: all stages empty, base_year returns to 1000.
module calendar_date_serial_converter import cdsc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [YEAR_W-1:0]   cfg_wdata,     // base_year
	input  logic                s_tvalid,
	output logic                s_tready,
	// s_tdata from bit 0: day_in[4:0], month_in[8:5], year_in[22:9],
	// serial_in[44:23], zero pad[47:45]
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                s_tuser,       // kind
	output logic                m_tvalid,
	input  logic                m_tready,
	// m_tdata from bit 0: serial_out[21:0], day_out[26:22], month_out[30:27],
	// year_out[44:31], weekday[47:45]
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tuser        // valid_res
);

	logic [YEAR_W-1:0] base_year_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic [9:1] adv;

	// Each stage moves when it is empty or the stage ahead moves.
	assign adv[9] = !v_s9 || m_tready;
	assign adv[8] = !v_s8 || adv[9];
	assign adv[7] = !v_s7 || adv[8];
	assign adv[6] = !v_s6 || adv[7];
	assign adv[5] = !v_s5 || adv[6];
	assign adv[4] = !v_s4 || adv[5];
	assign adv[3] = !v_s3 || adv[4];
	assign adv[2] = !v_s2 || adv[3];
	assign adv[1] = !v_s1 || adv[2];
	assign s_tready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_year_q <= YEAR_W'(BASE_RESET);
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (cfg_wen) begin
				base_year_q <= cfg_wdata;
			end
			if (adv[1]) v_s1 <= s_tvalid;
			if (adv[2]) v_s2 <= v_s1;
			if (adv[3]) v_s3 <= v_s2;
			if (adv[4]) v_s4 <= v_s3;
			if (adv[5]) v_s5 <= v_s4;
			if (adv[6]) v_s6 <= v_s5;
			if (adv[7]) v_s7 <= v_s6;
			if (adv[8]) v_s8 <= v_s7;
			if (adv[9]) v_s9 <= v_s8;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: capture the beat and the base year; run the divide-by-100
	// reciprocal products and the 365 multiples for both years.
	// ------------------------------------------------------------------
	logic [DAY_W-1:0]  in_day;
	logic [MON_W-1:0]  in_mon;
	logic [YEAR_W-1:0] in_year;
	logic [SER_W-1:0]  in_ser;

	assign in_day  = s_tdata[IN_DAY_LSB +: DAY_W];
	assign in_mon  = s_tdata[IN_MON_LSB +: MON_W];
	assign in_year = s_tdata[IN_YEAR_LSB +: YEAR_W];
	assign in_ser  = s_tdata[IN_SER_LSB +: SER_W];

	logic              kind_s1;
	logic [DAY_W-1:0]  dd_s1;
	logic [MON_W-1:0]  mm_s1;
	logic [YEAR_W-1:0] yy_s1, base_s1;
	logic [SER_W-1:0]  ser_s1;
	logic [ABS_W-1:0]  b365_s1, y365_s1;
	logic [8:0]        qb99_s1, qb399_s1, qy_s1, qy99_s1, qy399_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			kind_s1  <= s_tuser;
			dd_s1    <= in_day;
			mm_s1    <= in_mon;
			yy_s1    <= in_year;
			ser_s1   <= in_ser;
			base_s1  <= base_year_q;
			b365_s1  <= mul365(15'(base_year_q));
			y365_s1  <= mul365(15'(in_year));
			qb99_s1  <= div100(15'(base_year_q) + 15'd99);
			qb399_s1 <= div100(15'(base_year_q) + 15'd399);
			qy_s1    <= div100(15'(in_year));
			qy99_s1  <= div100(15'(in_year) + 15'd99);
			qy399_s1 <= div100(15'(in_year) + 15'd399);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: day numbers of both years, leap test, date validity and
	// the offset of the date inside its year.
	// ------------------------------------------------------------------
	logic [YEAR_W-1:0] r100_c;
	logic              leap_y_c, ok0_c;
	logic [DAY_W-1:0]  mlen_c;
	logic [9:0]        off_c;

	always_comb begin
		r100_c   = yy_s1 - YEAR_W'(14'(qy_s1) * 14'd100);
		leap_y_c = (yy_s1[1:0] == 2'd0) && ((r100_c != '0) || (qy_s1[1:0] == 2'd0));
		mlen_c   = month_len(mm_s1, leap_y_c);
		ok0_c    = (mm_s1 inside {[4'd1:4'd12]}) && (dd_s1 != '0) && (dd_s1 <= mlen_c)
			&& (yy_s1 >= base_s1) && (yy_s1 <= YEAR_W'(MAX_YEAR));
		off_c    = 10'(cum_days(mm_s1, leap_y_c)) + 10'(dd_s1) - 10'd1;
	end

	logic             kind_s2, ok0_s2;
	logic [SER_W-1:0] ser_s2;
	logic [ABS_W-1:0] dbb_s2, dby_s2;
	logic [9:0]       off_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			kind_s2 <= kind_s1;
			ok0_s2  <= ok0_c;
			ser_s2  <= ser_s1;
			dbb_s2  <= db_from_parts(b365_s1, 15'(base_s1), qb99_s1, qb399_s1);
			dby_s2  <= db_from_parts(y365_s1, 15'(yy_s1), qy99_s1, qy399_s1);
			off_s2  <= off_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: absolute day count for either kind, and the serial for kind 0.
	// ------------------------------------------------------------------
	logic [ABS_W-1:0] a0_c, a1_c;

	assign a0_c = dby_s2 + ABS_W'(off_s2);
	assign a1_c = dbb_s2 + ABS_W'(ser_s2);

	logic             kind_s3, ok0_s3;
	logic [ABS_W-1:0] abs_s3, ser0_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			kind_s3 <= kind_s2;
			ok0_s3  <= ok0_s2;
			abs_s3  <= (kind_s2 == KIND_SERIAL_TO_DATE) ? a1_c : a0_c;
			ser0_s3 <= a0_c - dbb_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: year estimate by reciprocal multiply (true year is the
	// estimate or one below); first mod-7 fold of the absolute count.
	// ------------------------------------------------------------------
	logic [2*ABS_W-1:0] est_prod_c;
	logic [5:0]         wf_c;

	always_comb begin
		est_prod_c = (2*ABS_W)'(abs_s3 + 24'd2) * (2*ABS_W)'(YEAR_RECIP);
		wf_c = '0;
		for (int i = 0; i < ABS_W / 3; i++) begin
			wf_c = wf_c + 6'(abs_s3[3*i +: 3]);
		end
	end

	logic             kind_s4, ok0_s4;
	logic [ABS_W-1:0] abs_s4;
	logic [SER_W-1:0] ser0_s4;
	logic [EST_W-1:0] est_s4;
	logic [5:0]       wf_s4;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			kind_s4 <= kind_s3;
			ok0_s4  <= ok0_s3 && (ser0_s3 <= ABS_W'(SERIAL_MAX));
			abs_s4  <= abs_s3;
			ser0_s4 <= ser0_s3[SER_W-1:0];
			est_s4  <= est_prod_c[32 +: EST_W];
			wf_s4   <= wf_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: products for the three candidate years around the estimate.
	// ------------------------------------------------------------------
	logic             kind_s5, ok0_s5;
	logic [ABS_W-1:0] abs_s5;
	logic [SER_W-1:0] ser0_s5;
	logic [EST_W-1:0] est_s5;
	logic [3:0]       wf2_s5;
	logic [ABS_W-1:0] c365_s5 [LANES];
	logic [8:0]       q99_s5  [LANES];
	logic [8:0]       q399_s5 [LANES];

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			kind_s5 <= kind_s4;
			ok0_s5  <= ok0_s4;
			abs_s5  <= abs_s4;
			ser0_s5 <= ser0_s4;
			est_s5  <= est_s4;
			wf2_s5  <= 4'(wf_s4[2:0]) + 4'(wf_s4[5:3]);
			for (int i = 0; i < LANES; i++) begin
				c365_s5[i] <= mul365(cand_year(est_s4, 2'(i)));
				q99_s5[i]  <= div100(cand_year(est_s4, 2'(i)) + 15'd99);
				q399_s5[i] <= div100(cand_year(est_s4, 2'(i)) + 15'd399);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: day numbers of the candidates; weekday from the mod-7 fold
	// (day 0 of year 0 is a Saturday, hence the offset of five).
	// ------------------------------------------------------------------
	logic [3:0] w7_c;
	logic [WD_W-1:0] wd_c;

	always_comb begin
		if (wf2_s5 >= 4'd14) begin
			w7_c = wf2_s5 - 4'd14;
		end else if (wf2_s5 >= 4'd7) begin
			w7_c = wf2_s5 - 4'd7;
		end else begin
			w7_c = wf2_s5;
		end
		wd_c = (w7_c >= 4'd2) ? WD_W'(w7_c - 4'd2) : WD_W'(w7_c + 4'd5);
	end

	logic             kind_s6, ok0_s6;
	logic [ABS_W-1:0] abs_s6;
	logic [SER_W-1:0] ser0_s6;
	logic [EST_W-1:0] est_s6;
	logic [WD_W-1:0]  wd_s6;
	logic [ABS_W-1:0] db_s6 [LANES];

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			kind_s6 <= kind_s5;
			ok0_s6  <= ok0_s5;
			abs_s6  <= abs_s5;
			ser0_s6 <= ser0_s5;
			est_s6  <= est_s5;
			wd_s6   <= wd_c;
			for (int i = 0; i < LANES; i++) begin
				db_s6[i] <= db_from_parts(c365_s5[i], cand_year(est_s5, 2'(i)),
					q99_s5[i], q399_s5[i]);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: pick the year, its leap flag and the day inside the year.
	// ------------------------------------------------------------------
	logic             sel_c;
	logic [EST_W-1:0] yc_c;
	logic [ABS_W-1:0] dby_c, dbn_c;

	always_comb begin
		sel_c = (db_s6[LANE_0] <= abs_s6);
		yc_c  = sel_c ? est_s6 : cand_year(est_s6, LANE_M1);
		dby_c = sel_c ? db_s6[LANE_0] : db_s6[LANE_M1];
		dbn_c = sel_c ? db_s6[LANE_P1] : db_s6[LANE_0];
	end

	logic              kind_s7, ok0_s7, ok1_s7, leap_s7;
	logic [SER_W-1:0]  ser0_s7;
	logic [WD_W-1:0]   wd_s7;
	logic [YEAR_W-1:0] y_s7;
	logic [8:0]        rem_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			kind_s7 <= kind_s6;
			ok0_s7  <= ok0_s6;
			ser0_s7 <= ser0_s6;
			wd_s7   <= wd_s6;
			ok1_s7  <= (yc_c <= EST_W'(MAX_YEAR));
			y_s7    <= yc_c[YEAR_W-1:0];
			leap_s7 <= ((dbn_c - dby_c) == ABS_W'(366));
			rem_s7  <= 9'(abs_s6 - dby_c);
		end
	end

	// ------------------------------------------------------------------
	// Stage 8: month by comparing the day of year with every month start.
	// ------------------------------------------------------------------
	logic [MON_W-1:0] mon_c;

	always_comb begin
		mon_c = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			mon_c = mon_c + 4'(rem_s7 >= cum_days(4'(k), leap_s7));
		end
	end

	logic              kind_s8, ok0_s8, ok1_s8, leap_s8;
	logic [SER_W-1:0]  ser0_s8;
	logic [WD_W-1:0]   wd_s8;
	logic [YEAR_W-1:0] y_s8;
	logic [8:0]        rem_s8;
	logic [MON_W-1:0]  mon_s8;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			kind_s8 <= kind_s7;
			ok0_s8  <= ok0_s7;
			ok1_s8  <= ok1_s7;
			leap_s8 <= leap_s7;
			ser0_s8 <= ser0_s7;
			wd_s8   <= wd_s7;
			y_s8    <= y_s7;
			rem_s8  <= rem_s7;
			mon_s8  <= mon_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 9: output register; zero every field of an invalid result.
	// ------------------------------------------------------------------
	logic [DAY_W-1:0] day_c;

	assign day_c = DAY_W'(rem_s8 - cum_days(mon_s8, leap_s8) + 9'd1);

	logic [SER_W-1:0]  ser_s9;
	logic [DAY_W-1:0]  day_s9;
	logic [MON_W-1:0]  mon_s9;
	logic [YEAR_W-1:0] year_s9;
	logic [WD_W-1:0]   wd_s9;
	logic              vres_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			if (kind_s8 == KIND_SERIAL_TO_DATE) begin
				vres_s9 <= ok1_s8;
				ser_s9  <= '0;
				day_s9  <= ok1_s8 ? day_c : '0;
				mon_s9  <= ok1_s8 ? mon_s8 : '0;
				year_s9 <= ok1_s8 ? y_s8 : '0;
				wd_s9   <= ok1_s8 ? wd_s8 : '0;
			end else begin
				vres_s9 <= ok0_s8;
				ser_s9  <= ok0_s8 ? ser0_s8 : '0;
				day_s9  <= '0;
				mon_s9  <= '0;
				year_s9 <= '0;
				wd_s9   <= ok0_s8 ? wd_s8 : '0;
			end
		end
	end

	assign m_tvalid = v_s9;
	assign m_tdata  = {wd_s9, year_s9, mon_s9, day_s9, ser_s9};
	assign m_tuser  = vres_s9;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata == '0))
		else $error("invalid result carries non-zero data");

	a_weekday_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (wd_s9 <= 3'd6))
		else $error("weekday out of range");

	a_date_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (mon_s9 != '0) |->
			(ser_s9 == '0) && (mon_s9 <= 4'd12) && (day_s9 != '0) && m_tuser)
		else $error("date result malformed");

	a_feb_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (mon_s9 == 4'd2) |-> (day_s9 <= 5'd29))
		else $error("February day past 29");

endmodule
